>>> hdl/cpd_pkg.sv
package cpd_pkg;

  localparam int ByteW = 8;
  localparam int CrcW  = 16;
  localparam int AddrW = 3;
  localparam int DataW = 32;

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_SOP     = 3'd1;
  localparam logic [2:0] ST_TYPE    = 3'd2;
  localparam logic [2:0] ST_LEN     = 3'd3;
  localparam logic [2:0] ST_CRCLO   = 3'd4;
  localparam logic [2:0] ST_PAYLOAD = 3'd5;

  localparam logic [CrcW-1:0]  CRC_INIT         = 16'hFFFF;
  localparam logic [ByteW-1:0] START_BYTE_RESET = 8'hA1;
  localparam logic [ByteW-1:0] MAX_LENGTH_RESET = 8'd200;

  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] max_length;
  } cfg_t;

  // MCRF4XX byte update of the CRC-16.
  function automatic logic [CrcW-1:0] crc_step(input logic [ByteW-1:0] in_byte,
                                               input logic [CrcW-1:0]  crc);
    logic [ByteW-1:0] b;
    b = in_byte ^ crc[7:0];
    b = b ^ {b[3:0], 4'h0};
    crc_step = {b, crc[15:8]} ^ {12'h000, b[7:4]} ^ {5'b00000, b, 3'b000};
  endfunction

endpackage

>>> hdl/cpd_regs.sv
module cpd_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [cpd_pkg::AddrW-1:0] paddr,
  input  logic [cpd_pkg::DataW-1:0] pwdata,
  output logic [cpd_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output cpd_pkg::cfg_t            cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= cpd_pkg::START_BYTE_RESET;
      cfg.max_length <= cpd_pkg::MAX_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        cpd_pkg::REG_START_BYTE: cfg.start_byte <= pwdata[cpd_pkg::ByteW-1:0];
        cpd_pkg::REG_MAX_LENGTH: cfg.max_length <= pwdata[cpd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cpd_pkg::REG_START_BYTE: prdata = {24'h000000, cfg.start_byte};
      cpd_pkg::REG_MAX_LENGTH: prdata = {24'h000000, cfg.max_length};
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> hdl/crc16_packet_deframer_top.sv
// Channel  Dir  Data                                          Side bits
// s_*      in   tdata[7:0] rx_byte                            -
// m_*      out  tdata: payload_byte, payload_index,           tuser: payload_valid, crc_ok
//                      packet_type, packet_length             tlast: packet_end
// APB      in   start_byte at 0x0, max_length at 0x4          -
//
// Each byte is held in the input register and then decoded into the result register;
// the frame state, stored fields and running CRC update in that same cycle.
// One byte per cycle is sustained while m_tready stays high. Bytes with no result (hunt,
// start, type, length, CRC low, CRC high if length is nonzero) are absorbed silently.
// A stalled result register stops the input register, which then drops s_tready.
// Reset is synchronous and returns the block to hunting with the default registers.
module crc16_packet_deframer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                               // [23:16] packet_type, [31:24] packet_length
  output logic                      m_tlast,   // packet_end
  output logic [1:0]                m_tuser,   // [0] payload_valid, [1] crc_ok
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cpd_pkg::AddrW-1:0] paddr,
  input  logic [cpd_pkg::DataW-1:0] pwdata,
  output logic [cpd_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  cpd_pkg::cfg_t cfg;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  logic [2:0]  frame_state, frame_state_next;
  logic [7:0]  stored_type, stored_type_next;
  logic [7:0]  stored_length, stored_length_next;
  logic [15:0] received_crc, received_crc_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  byte_count, byte_count_next;

  logic        res_valid;
  logic        res_payload;
  logic        res_end;
  logic        res_ok;
  logic [7:0]  res_index;
  logic [7:0]  res_type;
  logic [7:0]  res_length;
  logic [15:0] crc_upd;
  logic [15:0] rcrc_full;

  cpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  assign crc_upd   = cpd_pkg::crc_step(in_byte, running_crc);
  assign rcrc_full = {in_byte, received_crc[7:0]};

  always_comb begin
    frame_state_next   = frame_state;
    stored_type_next   = stored_type;
    stored_length_next = stored_length;
    received_crc_next  = received_crc;
    running_crc_next   = running_crc;
    byte_count_next    = byte_count;
    res_valid   = 1'b0;
    res_payload = 1'b0;
    res_end     = 1'b0;
    res_ok      = 1'b0;
    res_index   = '0;
    res_type    = '0;
    res_length  = '0;
    unique case (frame_state)
      cpd_pkg::ST_SOP: begin
        stored_type_next = in_byte;
        running_crc_next = crc_upd;
        frame_state_next = cpd_pkg::ST_TYPE;
      end
      cpd_pkg::ST_TYPE: begin
        if (in_byte <= cfg.max_length) begin
          stored_length_next = in_byte;
          running_crc_next   = crc_upd;
          frame_state_next   = cpd_pkg::ST_LEN;
        end
      end
      cpd_pkg::ST_LEN: begin
        received_crc_next = {8'h00, in_byte};
        frame_state_next  = cpd_pkg::ST_CRCLO;
      end
      cpd_pkg::ST_CRCLO: begin
        received_crc_next = rcrc_full;
        frame_state_next  = cpd_pkg::ST_PAYLOAD;
        if (stored_length == 8'h00) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_type   = stored_type;
          res_ok     = (running_crc == rcrc_full);
          frame_state_next   = cpd_pkg::ST_HUNT;
          stored_type_next   = '0;
          stored_length_next = '0;
          received_crc_next  = '0;
          running_crc_next   = cpd_pkg::CRC_INIT;
          byte_count_next    = '0;
        end
      end
      cpd_pkg::ST_PAYLOAD: begin
        res_valid        = 1'b1;
        res_payload      = 1'b1;
        res_index        = byte_count;
        running_crc_next = crc_upd;
        byte_count_next  = byte_count + 8'd1;
        if (byte_count_next == stored_length) begin
          res_end    = 1'b1;
          res_type   = stored_type;
          res_length = stored_length;
          res_ok     = (crc_upd == received_crc);
          frame_state_next   = cpd_pkg::ST_HUNT;
          stored_type_next   = '0;
          stored_length_next = '0;
          received_crc_next  = '0;
          running_crc_next   = cpd_pkg::CRC_INIT;
          byte_count_next    = '0;
        end
      end
      default: begin
        frame_state_next   = (in_byte == cfg.start_byte) ? cpd_pkg::ST_SOP : cpd_pkg::ST_HUNT;
        stored_type_next   = '0;
        stored_length_next = '0;
        received_crc_next  = '0;
        running_crc_next   = cpd_pkg::CRC_INIT;
        byte_count_next    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state   <= cpd_pkg::ST_HUNT;
      stored_type   <= '0;
      stored_length <= '0;
      received_crc  <= '0;
      running_crc   <= cpd_pkg::CRC_INIT;
      byte_count    <= '0;
    end else if (advance) begin
      frame_state   <= frame_state_next;
      stored_type   <= stored_type_next;
      stored_length <= stored_length_next;
      received_crc  <= received_crc_next;
      running_crc   <= running_crc_next;
      byte_count    <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res_length, res_type, res_index, res_payload ? in_byte : 8'h00};
      m_tlast <= res_end;
      m_tuser <= {res_ok, res_payload};
    end
  end

endmodule

>>> test/deframe_checker.sv
module deframe_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [31:0]               m_tdata,
  input  logic                      m_tlast,
  input  logic [1:0]                m_tuser,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [cpd_pkg::AddrW-1:0] paddr,
  input  logic [cpd_pkg::DataW-1:0] pwdata,
  output int                        fail_count,
  output int                        results_waiting,
  output int                        bytes_seen,
  output int                        payload_seen,
  output int                        good_packets,
  output int                        bad_packets
);

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       packet_end;
    logic [7:0] packet_type;
    logic [7:0] packet_length;
    logic       crc_ok;
  } deframe_result_t;

  logic [7:0]      start_byte;
  logic [7:0]      max_length;
  logic [2:0]      frame_state;
  logic [7:0]      type_q;
  logic [7:0]      length_q;
  logic [7:0]      count_q;
  logic [15:0]     rx_crc;
  logic [15:0]     calc_crc;
  deframe_result_t expected_q[$];

  // Bitwise form of the reflected CCITT update (polynomial 0x8408).
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_frame();
    frame_state = cpd_pkg::ST_HUNT;
    type_q      = 8'h00;
    length_q    = 8'h00;
    count_q     = 8'h00;
    rx_crc      = 16'h0000;
    calc_crc    = cpd_pkg::CRC_INIT;
  endtask

  task automatic close_packet(inout deframe_result_t r);
    r.packet_end    = 1'b1;
    r.packet_type   = type_q;
    r.packet_length = length_q;
    r.crc_ok        = (calc_crc == rx_crc);
    if (r.crc_ok) begin
      good_packets++;
    end else begin
      bad_packets++;
    end
    clear_frame();
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    deframe_result_t r;
    bit              emit;
    r    = '0;
    emit = 1'b0;
    case (frame_state)
      cpd_pkg::ST_SOP: begin
        type_q      = b;
        calc_crc    = crc_fold(calc_crc, b);
        frame_state = cpd_pkg::ST_TYPE;
      end
      cpd_pkg::ST_TYPE: begin
        if (b <= max_length) begin
          length_q    = b;
          calc_crc    = crc_fold(calc_crc, b);
          frame_state = cpd_pkg::ST_LEN;
        end
      end
      cpd_pkg::ST_LEN: begin
        rx_crc      = {8'h00, b};
        frame_state = cpd_pkg::ST_CRCLO;
      end
      cpd_pkg::ST_CRCLO: begin
        rx_crc[15:8] = b;
        if (length_q == 8'h00) begin
          emit = 1'b1;
          close_packet(r);
        end else begin
          frame_state = cpd_pkg::ST_PAYLOAD;
        end
      end
      cpd_pkg::ST_PAYLOAD: begin
        emit            = 1'b1;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = count_q;
        payload_seen++;
        calc_crc        = crc_fold(calc_crc, b);
        count_q         = count_q + 8'd1;
        if (count_q == length_q) begin
          close_packet(r);
        end
      end
      default: begin
        if (b == start_byte) begin
          clear_frame();
          frame_state = cpd_pkg::ST_SOP;
        end else begin
          frame_state = cpd_pkg::ST_HUNT;
        end
      end
    endcase
    if (emit) begin
      expected_q.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s expected 0x%h, got 0x%h", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_result();
    deframe_result_t want;
    deframe_result_t got;
    got.payload_valid = m_tuser[0];
    got.payload_byte  = m_tdata[7:0];
    got.payload_index = m_tdata[15:8];
    got.packet_type   = m_tdata[23:16];
    got.packet_length = m_tdata[31:24];
    got.packet_end    = m_tlast;
    got.crc_ok        = m_tuser[1];
    if (expected_q.size() == 0) begin
      fail_count++;
      $display("%0t: result with none expected, tdata 0x%h tuser %b tlast %b",
               $time, m_tdata, m_tuser, m_tlast);
    end else begin
      want = expected_q.pop_front();
      compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("packet_end", 8'(want.packet_end), 8'(got.packet_end));
      compare_field("packet_type", want.packet_type, got.packet_type);
      compare_field("packet_length", want.packet_length, got.packet_length);
      compare_field("crc_ok", 8'(want.crc_ok), 8'(got.crc_ok));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_byte      = cpd_pkg::START_BYTE_RESET;
      max_length      = cpd_pkg::MAX_LENGTH_RESET;
      clear_frame();
      expected_q.delete();
      fail_count      = 0;
      results_waiting = 0;
      bytes_seen      = 0;
      payload_seen    = 0;
      good_packets    = 0;
      bad_packets     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {cpd_pkg::REG_START_BYTE, 2'b00}) begin
          start_byte = pwdata[7:0];
        end else if (paddr == {cpd_pkg::REG_MAX_LENGTH, 2'b00}) begin
          max_length = pwdata[7:0];
        end
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
      if (s_tvalid && s_tready) begin
        bytes_seen++;
        absorb_byte(s_tdata);
      end
      results_waiting = expected_q.size();
    end
  end

endmodule

>>> test/testbench.sv
module testbench;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [7:0]                  s_tdata;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [31:0]                 m_tdata;
  logic                        m_tlast;
  logic [1:0]                  m_tuser;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [cpd_pkg::AddrW-1:0]   paddr;
  logic [cpd_pkg::DataW-1:0]   pwdata;
  logic [cpd_pkg::DataW-1:0]   prdata;
  logic                        pready;

  int fail_count;
  int results_waiting;
  int bytes_seen;
  int payload_seen;
  int good_packets;
  int bad_packets;

  logic [7:0] link_q[$];
  logic [7:0] cur_start;
  logic [7:0] cur_max;
  bit         hold_req;
  bit         hold_served;

  crc16_packet_deframer_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  deframe_checker deframe_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .results_waiting (results_waiting),
    .bytes_seen      (bytes_seen),
    .payload_seen    (payload_seen),
    .good_packets    (good_packets),
    .bad_packets     (bad_packets)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  task automatic reg_write(input logic [cpd_pkg::AddrW-1:0] addr, input logic [7:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] start_v, input logic [7:0] max_v);
    reg_write({cpd_pkg::REG_START_BYTE, 2'b00}, start_v);
    reg_write({cpd_pkg::REG_MAX_LENGTH, 2'b00}, max_v);
    cur_start = start_v;
    cur_max   = max_v;
  endtask

  task automatic queue_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == cur_start);
      link_q.push_back(b);
    end
  endtask

  task automatic queue_packet(input logic [7:0] ptype, input int len, input bit bad_crc,
                              input int n_oversize);
    logic [15:0] crc;
    logic [7:0]  body[$];
    logic [7:0]  b;
    crc = cpd_pkg::CRC_INIT;
    link_q.push_back(cur_start);
    link_q.push_back(ptype);
    crc = crc_next(crc, ptype);
    if (cur_max < 8'd255) begin
      for (int k = 0; k < n_oversize; k++) begin
        if (k == 0) begin
          b = cur_max + 8'd1;
        end else if (k == 1) begin
          b = 8'd255;
        end else begin
          b = 8'($urandom_range(cur_max + 1, 255));
        end
        link_q.push_back(b);
      end
    end
    link_q.push_back(len[7:0]);
    crc = crc_next(crc, len[7:0]);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      body.push_back(b);
      crc = crc_next(crc, b);
    end
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    link_q.push_back(crc[7:0]);
    link_q.push_back(crc[15:8]);
    foreach (body[i]) begin
      link_q.push_back(body[i]);
    end
  endtask

  // Mostly well-formed packets with random content, mixed with noise and cut-off headers.
  task automatic random_traffic(input int n_bytes);
    int r;
    int hi;
    int len;
    queue_packet(8'($urandom_range(0, 255)), cur_max, 1'b0, 0);
    while (link_q.size() < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_noise($urandom_range(1, 5));
      end else if (r < 12) begin
        link_q.push_back(cur_start);
        repeat ($urandom_range(0, 2)) link_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        hi  = (cur_max < 12) ? cur_max : 12;
        len = ($urandom_range(0, 99) < 2) ? cur_max : $urandom_range(0, hi);
        queue_packet(8'($urandom_range(0, 255)), len, $urandom_range(0, 9) == 0,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      end
    end
  endtask

  task automatic send_all();
    int burst;
    int gap;
    while (link_q.size() > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
      end
      while (burst > 0 && link_q.size() > 0) begin
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = link_q[0];
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        void'(link_q.pop_front());
        burst--;
      end
    end
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk); while (results_waiting != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int mode;
    int span;
    int tick;
    tick     = 0;
    m_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_req && !hold_served) begin
          m_tready = 1'b0;
          repeat (120) @(negedge clk);
          hold_served = 1'b1;
        end else begin
          case (mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            2: m_tready = ($urandom_range(0, 3) == 0);
            default: m_tready = (tick % 3 != 2);
          endcase
        end
        tick++;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= 3000) begin
        $display("Watchdog: no request moved for %0d cycles", quiet);
        $display("[crc16_packet_deframer_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_req    = 1'b0;
    hold_served = 1'b0;
    cur_start   = cpd_pkg::START_BYTE_RESET;
    cur_max     = cpd_pkg::MAX_LENGTH_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_noise(1);
    link_q.push_back(8'h00);
    link_q.push_back(8'hFF);
    queue_packet(8'h00, 0, 1'b0, 0);
    queue_packet(8'hFF, 1, 1'b0, 2);
    queue_packet(8'h5A, 2, 1'b1, 0);
    random_traffic(450);
    send_all();
    settle();

    set_config(8'h00, 8'd255);
    random_traffic(550);
    hold_req = 1'b1;
    send_all();
    settle();

    set_config(8'hFF, 8'd0);
    random_traffic(250);
    send_all();
    settle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 30)));
    random_traffic(400);
    send_all();
    settle();

    $display("Covered %0d link bytes, %0d payload bytes and %0d packets (%0d good CRC, %0d bad).",
             bytes_seen, payload_seen, good_packets + bad_packets, good_packets, bad_packets);
    $display("Settings ran from start bytes 0x00 and 0xFF and length limits 0 to 255.");
    if (fail_count == 0 && results_waiting == 0) begin
      $display("[crc16_packet_deframer_top] OK");
    end else begin
      $display("[crc16_packet_deframer_top] ERROR");
    end
    $finish;
  end

endmodule
